// ===== design/rse_pkg.sv =====
`default_nettype none

package rse_pkg;

  // Store geometry
  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned IDX_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned RND_W     = 16;
  localparam int unsigned RND_CNT_W = $clog2(RND_W);

  // Read-out reduction: cells are ORed in groups, one register per group
  localparam int unsigned GRP_SIZE  = 8;
  localparam int unsigned NUM_GRP   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  // Operation codes (tuser of the input stream)
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_RANDOM = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_MATCH = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_EMPTY = 2'd3;

  // Broadcast from the sequencer to every cell of the row
  typedef struct packed {
    logic [VAL_W-1:0] key;     // value looked up, and appended on insert
    logic [CNT_W-1:0] count;   // live count, bounds the lookup
    logic [IDX_W-1:0] sel;     // cell selected for read-out
    logic             app_we;  // append key at index count
    logic             hit_we;  // overwrite the matching cell with wdata
    logic [VAL_W-1:0] wdata;   // last element, moved in on remove
  } rse_ctrl_t;

endpackage

`default_nettype wire

// ===== design/randomized_set_engine.sv =====
// Set of up to 64 distinct signed 32-bit values, held in a row of cells, one
// element per cell, packed from cell 0 up to the live count. A request carries
// an operation in s_axis_tuser (insert, remove, get random) and takes one
// request at a time: insert and code 3 finish after the compare and lookup
// states, remove adds a read-out of the last element, and get random adds
// the bit-serial modulo of the 16-bit random word by the live count (one
// quotient bit per cycle) and a read-out. Every cell compares its element
// against the requested value in the cycle after the request is taken and
// registers the match; a read-out goes through a registered OR of the cells
// in groups of eight. Remove moves the last element into the freed cell. The
// next request is taken while a result still waits in the output register.
`default_nettype none

module randomized_set_engine
  import rse_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // [31:0] value, [47:32] random_word
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata    // [1:0] status, [33:2] value_out,
                                           // [40:34] count, rest zero
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_LOOK,
    ST_MOD,
    ST_READ,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [1:0]       kind_q;
  logic [VAL_W-1:0] key_q;
  logic [RND_W-1:0] rnd_q;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] sel_q;
  logic [1:0]       rdcnt_q;
  logic [1:0]       status_q;
  logic [VAL_W-1:0] vout_q;
  logic             out_valid_q;
  logic [47:0]      out_data_q;

  logic             app_we;
  logic             hit_we;
  logic             mod_start;
  logic             mod_done;
  logic [IDX_W-1:0] mod_rem;
  logic             any_hit;
  logic [VAL_W-1:0] rd_val;
  logic             accept;
  logic             out_free;

  logic [CAPACITY-1:0] hits;
  logic [VAL_W-1:0]    cell_rd [CAPACITY];
  logic [VAL_W-1:0]    grp_q   [NUM_GRP];
  rse_ctrl_t           ctrl;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Broadcast to the cells
  always_comb begin
    ctrl.key    = key_q;
    ctrl.count  = count_q;
    ctrl.sel    = sel_q;
    ctrl.app_we = app_we;
    ctrl.hit_we = hit_we;
    ctrl.wdata  = rd_val;
  end

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rse_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (IDX_W'(i)),
      .ctrl_i (ctrl),
      .hit_o  (hits[i]),
      .rd_o   (cell_rd[i])
    );
  end

  assign any_hit = |hits;

  // Registered group stage of the read-out OR
  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    always_ff @(posedge clk_i) begin
      logic [VAL_W-1:0] acc;
      acc = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < CAPACITY) begin
          acc = acc | cell_rd[g * GRP_SIZE + j];
        end
      end
      grp_q[g] <= acc;
    end
  end

  always_comb begin
    rd_val = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      rd_val = rd_val | grp_q[g];
    end
  end

  // Modulo of the random word by the live count
  rse_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rnd_q),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Cell write strobes and modulo start
  always_comb begin
    app_we    = 1'b0;
    hit_we    = 1'b0;
    mod_start = 1'b0;
    if (state_q == ST_LOOK) begin
      if (kind_q == KIND_INSERT && !any_hit && count_q < CNT_W'(CAPACITY)) begin
        app_we = 1'b1;
      end
      if (kind_q == KIND_RANDOM && count_q != '0) begin
        mod_start = 1'b1;
      end
    end
    if (state_q == ST_READ && rdcnt_q == 2'd2 && kind_q == KIND_REMOVE) begin
      hit_we = 1'b1;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // Request sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      kind_q      <= KIND_INSERT;
      key_q       <= '0;
      rnd_q       <= '0;
      sel_q       <= '0;
      rdcnt_q     <= '0;
      status_q    <= STATUS_OK;
      vout_q      <= '0;
    end else begin
      // Result register: load on completion, clear once taken
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            kind_q  <= s_axis_tuser;
            key_q   <= s_axis_tdata[31:0];
            rnd_q   <= s_axis_tdata[47:32];
            state_q <= ST_CMP;
          end
        end
        // cells register their match against the new key
        ST_CMP: begin
          state_q <= ST_LOOK;
        end
        ST_LOOK: begin
          status_q <= STATUS_OK;
          vout_q   <= '0;
          state_q  <= ST_DONE;
          case (kind_q)
            KIND_INSERT: begin
              if (any_hit) begin
                status_q <= STATUS_MATCH;
              end else if (count_q >= CNT_W'(CAPACITY)) begin
                status_q <= STATUS_FULL;
              end else begin
                count_q <= count_q + 1'b1;
              end
            end
            KIND_REMOVE: begin
              if (!any_hit) begin
                status_q <= STATUS_MATCH;
              end else begin
                sel_q   <= IDX_W'(count_q - 1'b1);
                rdcnt_q <= '0;
                state_q <= ST_READ;
              end
            end
            KIND_RANDOM: begin
              if (count_q == '0) begin
                status_q <= STATUS_EMPTY;
              end else begin
                state_q <= ST_MOD;
              end
            end
            default: begin
            end
          endcase
        end
        ST_MOD: begin
          if (mod_done) begin
            sel_q   <= mod_rem;
            rdcnt_q <= '0;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          rdcnt_q <= rdcnt_q + 1'b1;
          if (rdcnt_q == 2'd2) begin
            if (kind_q == KIND_REMOVE) begin
              count_q <= count_q - 1'b1;
            end else begin
              vout_q <= rd_val;
            end
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_q <= {7'd0, count_q, vout_q, status_q};
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== design/rse_cell.sv =====
`default_nettype none

module rse_cell
  import rse_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic [IDX_W-1:0] idx_i,   // fixed position of this cell
  input  wire rse_ctrl_t        ctrl_i,
  output logic                  hit_o,
  output logic [VAL_W-1:0]      rd_o
);

  logic [VAL_W-1:0] val_q;
  logic             hit_q;
  logic [VAL_W-1:0] rd_q;
  logic             live;

  assign live = {1'b0, idx_i} < ctrl_i.count;

  // Element storage: append at the tail, or take the moved tail element
  always_ff @(posedge clk_i) begin
    if (ctrl_i.app_we && (idx_i == ctrl_i.count[IDX_W-1:0])) begin
      val_q <= ctrl_i.key;
    end else if (ctrl_i.hit_we && hit_q) begin
      val_q <= ctrl_i.wdata;
    end
  end

  // Local match and masked read-out, both registered
  always_ff @(posedge clk_i) begin
    hit_q <= live && (val_q == ctrl_i.key);
    rd_q  <= (idx_i == ctrl_i.sel) ? val_q : '0;
  end

  assign hit_o = hit_q;
  assign rd_o  = rd_q;

endmodule

`default_nettype wire

// ===== design/rse_mod.sv =====
`default_nettype none

module rse_mod
  import rse_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [RND_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [IDX_W-1:0]      rem_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [RND_CNT_W-1:0] cnt_q;
  logic [RND_W-1:0]     dvd_q;
  logic [CNT_W-1:0]     dsr_q;
  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, dvd_q[RND_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == RND_CNT_W'(RND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
      rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[IDX_W-1:0];

endmodule

`default_nettype wire

// ===== sim/rse_checker.sv =====
`timescale 1ns / 100ps

module rse_checker
  import rse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [31:0] value, [47:32] random_word
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // [1:0] status, [33:2] value_out,
                                      // [40:34] count, rest zero
  output int          mismatches_o,
  output int          pending_o
);

  // One answer of the set, as the output stream carries it
  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
  } set_reply_t;

  // Shadow copy of the set contents
  logic [VAL_W-1:0] shadow_members [CAPACITY];
  int unsigned      shadow_count = 0;
  set_reply_t       predicted_replies [$];
  int               mismatch_cnt = 0;
  int               waiting_cnt = 0;

  assign mismatches_o = mismatch_cnt;
  assign pending_o    = waiting_cnt;

  // Apply one request to the shadow set and return the answer it should give
  function automatic set_reply_t apply_set_op(input logic [1:0]       kind,
                                              input logic [VAL_W-1:0] v,
                                              input logic [RND_W-1:0] rnd);
    set_reply_t  r;
    int          slot;
    int unsigned pos;
    r.status = STATUS_OK;
    r.value  = '0;
    slot     = -1;
    for (pos = 0; pos < shadow_count; pos++) begin
      if (slot < 0 && shadow_members[pos] == v) slot = pos;
    end
    case (kind)
      KIND_INSERT: begin
        if (slot >= 0) begin
          r.status = STATUS_MATCH;
        end else if (shadow_count >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_members[shadow_count] = v;
          shadow_count++;
        end
      end
      KIND_REMOVE: begin
        if (slot < 0) begin
          r.status = STATUS_MATCH;
        end else begin
          // last element fills the hole
          shadow_members[slot] = shadow_members[shadow_count - 1];
          shadow_count--;
        end
      end
      KIND_RANDOM: begin
        if (shadow_count == 0) r.status = STATUS_EMPTY;
        else r.value = shadow_members[rnd % shadow_count];
      end
      default: ;  // spare code leaves the set alone
    endcase
    r.count = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  task automatic report_reply(input string why, input set_reply_t want,
                              input logic [47:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display({"%0t: %s: want status %0d value %h count %0d, ",
                "got status %0d value %h count %0d pad %h"},
               $realtime, why, want.status, want.value, want.count,
               got[1:0], got[33:2], got[40:34], got[47:41]);
  endtask

  // Compare on each accepted result, predict on each accepted request
  always @(posedge clk_i) begin
    set_reply_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_replies.size() == 0) begin
          report_reply("result with no request outstanding", '0, m_axis_tdata);
        end else begin
          want = predicted_replies.pop_front();
          if (m_axis_tdata[1:0] != want.status || m_axis_tdata[33:2] != want.value ||
              m_axis_tdata[40:34] != want.count || m_axis_tdata[47:41] != '0)
            report_reply("result mismatch", want, m_axis_tdata);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predicted_replies = {predicted_replies,
                             apply_set_op(s_axis_tuser, s_axis_tdata[31:0],
                                          s_axis_tdata[47:32])};
      waiting_cnt = predicted_replies.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rse_pkg::*;

  localparam logic [1:0] KIND_NOP = 2'd3;  // spare code, must not touch the set
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 425;
  localparam int SEGMENT_LEN     = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // [31:0] value, [47:32] random_word
  logic [1:0]  s_axis_tuser = '0;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [1:0] status, [33:2] value_out, [40:34] count
  int          mismatches;
  int          pending;

  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          holds_asked = 0;
  int          op_index = 0;
  logic [31:0] value_pool [$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  randomized_set_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rse_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  // Offer one request, with random idle cycles ahead of it
  task automatic send_op(input logic [1:0] kind, input logic [31:0] v,
                         input logic [15:0] rnd);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rnd, v};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Mostly known values so lookups hit; fill and drain segments sweep the count
  task automatic random_op();
    logic [1:0]  kind;
    logic [31:0] v;
    int          pick;
    pick = $urandom_range(99);
    if (((op_index / SEGMENT_LEN) % 2) == 0)
      kind = (pick < 78) ? KIND_INSERT : (pick < 88) ? KIND_REMOVE :
             (pick < 98) ? KIND_RANDOM : KIND_NOP;
    else
      kind = (pick < 15) ? KIND_INSERT : (pick < 85) ? KIND_REMOVE :
             (pick < 97) ? KIND_RANDOM : KIND_NOP;
    if ($urandom_range(99) < 92) begin
      v = value_pool[$urandom_range(value_pool.size() - 1)];
    end else begin
      v = $urandom();
      // fresh inserted values join the pool so they can be removed later
      if (kind == KIND_INSERT) value_pool = {value_pool, v};
    end
    op_index++;
    send_op(kind, v, 16'($urandom_range(16'hFFFF)));
  endtask

  // Result side: random stalls, plus long hold-offs on request
  initial begin
    int holds_done;
    holds_done = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_done < holds_asked) begin
        holds_done++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    repeat (72) value_pool = {value_pool, 32'($urandom())};

    // directed: empty store, extremes, duplicates, hole fill, spare code
    send_op(KIND_RANDOM, 32'h0000_0000, 16'hFFFF);
    send_op(KIND_REMOVE, 32'h0000_0000, 16'h0000);
    send_op(KIND_NOP,    32'h0000_0000, 16'h0000);
    send_op(KIND_INSERT, 32'h8000_0000, 16'h0000);
    send_op(KIND_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
    send_op(KIND_INSERT, 32'h0000_0000, 16'h0000);
    send_op(KIND_INSERT, 32'hFFFF_FFFF, 16'h0000);
    send_op(KIND_INSERT, 32'h7FFF_FFFF, 16'h0000);
    send_op(KIND_RANDOM, 32'h0000_0000, 16'h0000);
    send_op(KIND_RANDOM, 32'hFFFF_FFFF, 16'hFFFF);
    send_op(KIND_RANDOM, 32'h1234_5678, 16'hAAAA);
    send_op(KIND_RANDOM, 32'h0000_0000, 16'h5555);
    send_op(KIND_REMOVE, 32'h1234_5678, 16'h0000);
    send_op(KIND_REMOVE, 32'h8000_0000, 16'h0000);
    send_op(KIND_REMOVE, 32'hFFFF_FFFF, 16'h0000);
    send_op(KIND_NOP,    32'hFFFF_FFFF, 16'hFFFF);
    send_op(KIND_RANDOM, 32'hFFFF_FFFF, 16'h0001);
    send_op(KIND_REMOVE, 32'h7FFF_FFFF, 16'h0000);
    send_op(KIND_REMOVE, 32'h0000_0000, 16'h0000);
    send_op(KIND_RANDOM, 32'h0000_0000, 16'h0003);

    // random phases with changing back-pressure
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  holds_asked++; end
        1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
        default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
      endcase
      repeat (ITEMS_PER_PHASE) random_op();
    end
    s_axis_tvalid <= 1'b0;

    // drain, then allow for a late stray result
    do @(posedge clk_i); while (pending != 0);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
